/* design/nbg_pkg.sv */
// Shared types, codes and arithmetic helpers of the N-body gravity step block.
// Used by the controller, the datapath and the top level; depends on nothing.
package nbg_pkg;

  localparam int DATA_W         = 32;
  localparam int IDX_W          = 4;
  localparam int NAXES          = 3;
  localparam int MAX_BODIES_DEF = 16;

  localparam logic [0:0] REG_GRAV_CONST = 1'b0;
  localparam logic [0:0] REG_TIME_STEP  = 1'b1;
  localparam logic [DATA_W-1:0] GRAV_RESET = 32'd1;
  localparam logic [DATA_W-1:0] DT_RESET   = 32'd65536;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [4:0] DP_NOP       = 5'd0;
  localparam logic [4:0] DP_LOAD_WR   = 5'd1;
  localparam logic [4:0] DP_LATCH_I   = 5'd2;
  localparam logic [4:0] DP_LATCH_J   = 5'd3;
  localparam logic [4:0] DP_MUL_SQ    = 5'd4;
  localparam logic [4:0] DP_ACC_SQ    = 5'd5;
  localparam logic [4:0] DP_SQRT_GO   = 5'd6;
  localparam logic [4:0] DP_DIV_F     = 5'd7;
  localparam logic [4:0] DP_LATCH_F   = 5'd8;
  localparam logic [4:0] DP_DIV_U     = 5'd9;
  localparam logic [4:0] DP_LATCH_U   = 5'd10;
  localparam logic [4:0] DP_MUL_T     = 5'd11;
  localparam logic [4:0] DP_ACC_T     = 5'd12;
  localparam logic [4:0] DP_MUL_G     = 5'd13;
  localparam logic [4:0] DP_ACC_G     = 5'd14;
  localparam logic [4:0] DP_WR_ACC    = 5'd15;
  localparam logic [4:0] DP_LATCH_B   = 5'd16;
  localparam logic [4:0] DP_MUL_A     = 5'd17;
  localparam logic [4:0] DP_ACC_V     = 5'd18;
  localparam logic [4:0] DP_MUL_V     = 5'd19;
  localparam logic [4:0] DP_ACC_P     = 5'd20;
  localparam logic [4:0] DP_WR_PV     = 5'd21;
  localparam logic [4:0] DP_LATCH_OUT = 5'd22;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] axis;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic pinned;
    logic sq_zero;
    logic div_busy;
    logic sqrt_busy;
  } status_t;

  localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

  // Adds the Q16.16 product magnitude, with the given sign, to x and saturates.
  function automatic logic signed [31:0] scale_add(input logic signed [31:0] x,
                                                   input logic neg,
                                                   input logic [63:0] prod);
    logic signed [49:0] term;
    logic signed [49:0] s;
    term = $signed({2'b00, prod[63:16]});
    if (neg) begin
      term = -term;
    end
    s = $signed({{18{x[31]}}, x}) + term;
    if (s > SAT_HI) begin
      return 32'sh7fffffff;
    end else if (s < SAT_LO) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] n;
    n = -x;
    return x[31] ? n : x;
  endfunction

endpackage

/* design/n_body_gravity_step.sv */
// Fixed-point N-body gravity step with semi-implicit Euler integration.
// Depends on nbg_pkg, nbg_ctrl and nbg_datapath.
//
// A load transaction appends one body and is dropped once the table holds
// MAX_BODIES bodies. A step transaction runs a force pass over every ordered
// pair of bodies with an unpinned first body, an integration pass and then one
// result transaction per body in index order, with last on the final one. Each
// pair with distance uses the shared one-bit-per-cycle divider (four divisions)
// and the square root; a coincident pair uses neither. A pinned body skips force
// summing and integration. No new transaction is accepted until every result
// of a step has been taken. There is no clearing pass after reset.
module n_body_gravity_step import nbg_pkg::*; #(
  parameter int MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     opcode,
  input  logic [DATA_W-1:0]        body_mass,
  input  logic signed [DATA_W-1:0] pos_x,
  input  logic signed [DATA_W-1:0] pos_y,
  input  logic signed [DATA_W-1:0] pos_z,
  input  logic signed [DATA_W-1:0] vel_x,
  input  logic signed [DATA_W-1:0] vel_y,
  input  logic signed [DATA_W-1:0] vel_z,
  input  logic                     pinned,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         body_index,
  output logic signed [DATA_W-1:0] new_pos_x,
  output logic signed [DATA_W-1:0] new_pos_y,
  output logic signed [DATA_W-1:0] new_pos_z,
  output logic signed [DATA_W-1:0] new_vel_x,
  output logic signed [DATA_W-1:0] new_vel_y,
  output logic signed [DATA_W-1:0] new_vel_z,
  output logic                     last
);

  logic [DATA_W-1:0]             grav_const;
  logic [DATA_W-1:0]             time_step;
  cmd_t                          cmd;
  status_t                       status;
  logic [$clog2(MAX_BODIES)-1:0] addr;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIME_STEP) ? time_step : grav_const;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_const <= GRAV_RESET;
      time_step  <= DT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_GRAV_CONST) begin
        grav_const <= pwdata;
      end else begin
        time_step <= pwdata;
      end
    end
  end

  nbg_ctrl #(.MAX_BODIES(MAX_BODIES)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .opcode(opcode), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd), .addr(addr)
  );

  nbg_datapath #(.MAX_BODIES(MAX_BODIES)) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .addr(addr), .status(status),
    .grav(grav_const), .dt(time_step),
    .body_mass(body_mass), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .pinned(pinned),
    .body_index(body_index), .new_pos_x(new_pos_x), .new_pos_y(new_pos_y),
    .new_pos_z(new_pos_z), .new_vel_x(new_vel_x), .new_vel_y(new_vel_y),
    .new_vel_z(new_vel_z), .last(last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready && !out_valid)
    else $error("step did not end after the last result");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == OP_LOAD) |=> in_ready)
    else $error("load did not complete in one cycle");

endmodule

/* design/nbg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for every body table of the datapath.
module nbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/nbg_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Self-contained; shared by the force and unit-vector divisions.
module nbg_div #(
  parameter int NW = 62,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;

  assign shifted = {rem, quo[NW-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NW);
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      busy <= (cnt != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

/* design/nbg_sqrt.sv */
// Iterative integer square root, one result bit per cycle (floor of the root).
// Self-contained; used for the pair distance.
module nbg_sqrt #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   x,
  output logic           busy,
  output logic [W/2-1:0] root
);

  localparam int RW    = W / 2 + 3;
  localparam int CNT_W = $clog2(W / 2 + 1);

  logic [W-1:0]     xs;
  logic [RW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic [RW-1:0]    r2;
  logic [RW-1:0]    trial;

  assign r2    = {rem[RW-3:0], xs[W-1:W-2]};
  assign trial = RW'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(W / 2);
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      busy <= (cnt != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xs <= {xs[W-3:0], 2'b00};
      if (r2 >= trial) begin
        rem  <= r2 - trial;
        root <= {root[W/2-2:0], 1'b1};
      end else begin
        rem  <= r2;
        root <= {root[W/2-2:0], 1'b0};
      end
    end
  end

endmodule

/* design/nbg_datapath.sv */
// Datapath: body tables, shared multiplier, divider and square root unit.
// Depends on nbg_pkg, nbg_ram, nbg_div and nbg_sqrt; driven by nbg_ctrl commands.
module nbg_datapath import nbg_pkg::*; #(
  parameter int MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  input  logic [$clog2(MAX_BODIES)-1:0] addr,
  output status_t                       status,
  input  logic [DATA_W-1:0]             grav,
  input  logic [DATA_W-1:0]             dt,
  input  logic [DATA_W-1:0]             body_mass,
  input  logic signed [DATA_W-1:0]      pos_x,
  input  logic signed [DATA_W-1:0]      pos_y,
  input  logic signed [DATA_W-1:0]      pos_z,
  input  logic signed [DATA_W-1:0]      vel_x,
  input  logic signed [DATA_W-1:0]      vel_y,
  input  logic signed [DATA_W-1:0]      vel_z,
  input  logic                          pinned,
  output logic [IDX_W-1:0]              body_index,
  output logic signed [DATA_W-1:0]      new_pos_x,
  output logic signed [DATA_W-1:0]      new_pos_y,
  output logic signed [DATA_W-1:0]      new_pos_z,
  output logic signed [DATA_W-1:0]      new_vel_x,
  output logic signed [DATA_W-1:0]      new_vel_y,
  output logic signed [DATA_W-1:0]      new_vel_z,
  output logic                          last
);

  localparam int IW    = $clog2(MAX_BODIES);
  localparam int SUM_W = 35 + IW;
  localparam int VW    = NAXES * DATA_W;
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(32'sh7fffffff);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(32'sh80000000);

  logic [DATA_W:0] mass_rd;
  logic [VW-1:0]   pos_rd;
  logic [VW-1:0]   vel_rd;
  logic [VW-1:0]   acc_rd;
  logic [DATA_W:0] mass_wd;
  logic [VW-1:0]   pos_wd;
  logic [VW-1:0]   vel_wd;
  logic [VW-1:0]   acc_wd;
  logic            load_we;
  logic            pv_we;
  logic            acc_we;

  logic signed [DATA_W-1:0] pi  [NAXES];
  logic signed [DATA_W-1:0] vr  [NAXES];
  logic signed [DATA_W-1:0] acc [NAXES];
  logic signed [SUM_W-1:0]  sum [NAXES];
  logic [30:0]              hh  [NAXES];
  logic                     dneg[NAXES];
  logic [30:0]              hh_new  [NAXES];
  logic                     dneg_new[NAXES];
  logic [DATA_W-1:0]        mj;
  logic [63:0]              sq;
  logic [32:0]              f;
  logic [30:0]              u;
  logic [63:0]              prod;
  logic [31:0]              mul_a;
  logic [31:0]              mul_b;

  logic [61:0] div_num;
  logic [63:0] div_den;
  logic [61:0] quo;
  logic [31:0] pair_len;
  logic        div_busy;
  logic        sqrt_busy;

  logic signed [SUM_W-1:0] ssel;
  logic signed [SUM_W-1:0] sneg_val;
  logic [31:0]             smag;
  logic [64:0]             tfull;
  logic [SUM_W-1:0]        tz;
  logic [IW+IDX_W-1:0]     idx_w;

  assign load_we = (cmd.op == DP_LOAD_WR);
  assign pv_we   = load_we || (cmd.op == DP_WR_PV);
  assign acc_we  = (cmd.op == DP_WR_ACC);
  assign mass_wd = {pinned, body_mass};
  assign pos_wd  = load_we ? {pos_z, pos_y, pos_x} : {pi[2], pi[1], pi[0]};
  assign vel_wd  = load_we ? {vel_z, vel_y, vel_x} : {vr[2], vr[1], vr[0]};
  assign acc_wd  = {acc[2], acc[1], acc[0]};

  nbg_ram #(.WIDTH(DATA_W + 1), .DEPTH(MAX_BODIES)) u_mass_ram (
    .clk(clk), .we(load_we), .waddr(addr), .wdata(mass_wd), .raddr(addr), .rdata(mass_rd)
  );
  nbg_ram #(.WIDTH(VW), .DEPTH(MAX_BODIES)) u_pos_ram (
    .clk(clk), .we(pv_we), .waddr(addr), .wdata(pos_wd), .raddr(addr), .rdata(pos_rd)
  );
  nbg_ram #(.WIDTH(VW), .DEPTH(MAX_BODIES)) u_vel_ram (
    .clk(clk), .we(pv_we), .waddr(addr), .wdata(vel_wd), .raddr(addr), .rdata(vel_rd)
  );
  nbg_ram #(.WIDTH(VW), .DEPTH(MAX_BODIES)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(addr), .wdata(acc_wd), .raddr(addr), .rdata(acc_rd)
  );

  always_comb begin
    if (cmd.op == DP_DIV_F) begin
      div_num = {mj, 30'b0};
      div_den = sq;
    end else begin
      div_num = {1'b0, hh[cmd.axis], 30'b0};
      div_den = {32'b0, pair_len};
    end
  end

  nbg_div #(.NW(62), .DW(64)) u_div (
    .clk(clk), .rst(rst),
    .start((cmd.op == DP_DIV_F) || (cmd.op == DP_DIV_U)),
    .num(div_num), .den(div_den), .busy(div_busy), .quo(quo)
  );

  nbg_sqrt #(.W(64)) u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.op == DP_SQRT_GO),
    .x(sq), .busy(sqrt_busy), .root(pair_len)
  );

  assign status.pinned    = mass_rd[DATA_W];
  assign status.sq_zero   = (sq == 64'd0);
  assign status.div_busy  = div_busy;
  assign status.sqrt_busy = sqrt_busy;

  always_comb begin
    logic signed [32:0] d;
    logic [32:0]        dm;
    for (int k = 0; k < NAXES; k++) begin
      d  = $signed({pos_rd[k*DATA_W+DATA_W-1], pos_rd[k*DATA_W +: DATA_W]})
         - $signed({pi[k][DATA_W-1], pi[k]});
      dm = d[32] ? 33'(-d) : 33'(d);
      hh_new[k]   = dm[31:1];
      dneg_new[k] = d[32];
    end
  end

  always_comb begin
    ssel     = sum[cmd.axis];
    sneg_val = -ssel;
    if (ssel > SUM_HI) begin
      smag = 32'h7fffffff;
    end else if (ssel < SUM_LO) begin
      smag = 32'h80000000;
    end else if (ssel[SUM_W-1]) begin
      smag = sneg_val[31:0];
    end else begin
      smag = ssel[31:0];
    end
  end

  assign tfull = {1'b0, prod} + (f[32] ? {2'b00, u, 32'b0} : 65'd0);
  assign tz    = {{(SUM_W - 35){1'b0}}, tfull[64:30]};
  assign idx_w = {{IDX_W{1'b0}}, addr};

  always_comb begin
    case (cmd.op)
      DP_MUL_SQ: begin
        mul_a = {1'b0, hh[cmd.axis]};
        mul_b = {1'b0, hh[cmd.axis]};
      end
      DP_MUL_T: begin
        mul_a = f[31:0];
        mul_b = {1'b0, u};
      end
      DP_MUL_G: begin
        mul_a = smag;
        mul_b = grav;
      end
      DP_MUL_A: begin
        mul_a = mag32(acc[cmd.axis]);
        mul_b = dt;
      end
      DP_MUL_V: begin
        mul_a = mag32(vr[cmd.axis]);
        mul_b = dt;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    case (cmd.op)
      DP_LATCH_I: begin
        for (int k = 0; k < NAXES; k++) begin
          pi[k]  <= pos_rd[k*DATA_W +: DATA_W];
          sum[k] <= '0;
        end
      end
      DP_LATCH_J: begin
        mj <= mass_rd[DATA_W-1:0];
        sq <= '0;
        for (int k = 0; k < NAXES; k++) begin
          hh[k]   <= hh_new[k];
          dneg[k] <= dneg_new[k];
        end
      end
      DP_ACC_SQ: sq <= sq + prod;
      DP_LATCH_F: f <= (quo > 62'h1_ffff_ffff) ? 33'h1_ffff_ffff : quo[32:0];
      DP_LATCH_U: u <= (quo > 62'h4000_0000) ? 31'h4000_0000 : quo[30:0];
      DP_ACC_T: begin
        sum[cmd.axis] <= dneg[cmd.axis] ? sum[cmd.axis] - $signed(tz)
                                        : sum[cmd.axis] + $signed(tz);
      end
      DP_ACC_G: acc[cmd.axis] <= scale_add(32'sd0, ssel[SUM_W-1], prod);
      DP_LATCH_B: begin
        for (int k = 0; k < NAXES; k++) begin
          pi[k]  <= pos_rd[k*DATA_W +: DATA_W];
          vr[k]  <= vel_rd[k*DATA_W +: DATA_W];
          acc[k] <= acc_rd[k*DATA_W +: DATA_W];
        end
      end
      DP_ACC_V: vr[cmd.axis] <= scale_add(vr[cmd.axis], acc[cmd.axis][31], prod);
      DP_ACC_P: pi[cmd.axis] <= scale_add(pi[cmd.axis], vr[cmd.axis][31], prod);
      DP_LATCH_OUT: begin
        body_index <= idx_w[IDX_W-1:0];
        new_pos_x  <= pos_rd[0 +: DATA_W];
        new_pos_y  <= pos_rd[DATA_W +: DATA_W];
        new_pos_z  <= pos_rd[2*DATA_W +: DATA_W];
        new_vel_x  <= vel_rd[0 +: DATA_W];
        new_vel_y  <= vel_rd[DATA_W +: DATA_W];
        new_vel_z  <= vel_rd[2*DATA_W +: DATA_W];
        last       <= cmd.last;
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/nbg_ctrl.sv */
// Controller: sequences loads, the pairwise force pass, the integration pass
// and result output. Depends on nbg_pkg; commands nbg_datapath.
module nbg_ctrl import nbg_pkg::*; #(
  parameter int MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          opcode,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  status_t                       status,
  output cmd_t                          cmd,
  output logic [$clog2(MAX_BODIES)-1:0] addr
);

  localparam int IW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_A_RDI   = 5'd1;
  localparam logic [4:0] S_A_LATI  = 5'd2;
  localparam logic [4:0] S_A_RDJ   = 5'd3;
  localparam logic [4:0] S_A_LATJ  = 5'd4;
  localparam logic [4:0] S_A_MSQ   = 5'd5;
  localparam logic [4:0] S_A_ASQ   = 5'd6;
  localparam logic [4:0] S_A_CHK   = 5'd7;
  localparam logic [4:0] S_A_SQW   = 5'd8;
  localparam logic [4:0] S_A_DFW   = 5'd9;
  localparam logic [4:0] S_A_DU    = 5'd10;
  localparam logic [4:0] S_A_DUW   = 5'd11;
  localparam logic [4:0] S_A_MT    = 5'd12;
  localparam logic [4:0] S_A_AT    = 5'd13;
  localparam logic [4:0] S_A_NEXTJ = 5'd14;
  localparam logic [4:0] S_A_MG    = 5'd15;
  localparam logic [4:0] S_A_AG    = 5'd16;
  localparam logic [4:0] S_A_WRA   = 5'd17;
  localparam logic [4:0] S_A_NEXTI = 5'd18;
  localparam logic [4:0] S_B_RD    = 5'd19;
  localparam logic [4:0] S_B_LAT   = 5'd20;
  localparam logic [4:0] S_B_MA    = 5'd21;
  localparam logic [4:0] S_B_AV    = 5'd22;
  localparam logic [4:0] S_B_MV    = 5'd23;
  localparam logic [4:0] S_B_AP    = 5'd24;
  localparam logic [4:0] S_B_WR    = 5'd25;
  localparam logic [4:0] S_B_NEXT  = 5'd26;
  localparam logic [4:0] S_C_RD    = 5'd27;
  localparam logic [4:0] S_C_LAT   = 5'd28;
  localparam logic [4:0] S_C_OUT   = 5'd29;

  logic [4:0]    state, state_next;
  logic [IW-1:0] i, i_next;
  logic [IW-1:0] j, j_next;
  logic [1:0]    k, k_next;
  logic [CW-1:0] count, count_next;
  logic          last_i;
  logic          last_j;

  assign last_i    = (CW'(i) + CW'(1)) == count;
  assign last_j    = (CW'(j) + CW'(1)) == count;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_C_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    count_next = count;
    cmd.op     = DP_NOP;
    cmd.axis   = k;
    cmd.last   = last_i;
    addr       = i;
    case (state)
      S_IDLE: begin
        addr = count[IW-1:0];
        if (in_valid) begin
          if (opcode == OP_LOAD) begin
            if (count < CW'(MAX_BODIES)) begin
              cmd.op     = DP_LOAD_WR;
              count_next = count + CW'(1);
            end
          end else if (count != '0) begin
            i_next     = '0;
            state_next = S_A_RDI;
          end
        end
      end
      S_A_RDI: state_next = S_A_LATI;
      S_A_LATI: begin
        cmd.op = DP_LATCH_I;
        j_next = '0;
        state_next = status.pinned ? S_A_NEXTI : S_A_RDJ;
      end
      S_A_RDJ: begin
        addr = j;
        state_next = (j == i) ? S_A_NEXTJ : S_A_LATJ;
      end
      S_A_LATJ: begin
        addr       = j;
        cmd.op     = DP_LATCH_J;
        k_next     = '0;
        state_next = S_A_MSQ;
      end
      S_A_MSQ: begin
        cmd.op     = DP_MUL_SQ;
        state_next = S_A_ASQ;
      end
      S_A_ASQ: begin
        cmd.op = DP_ACC_SQ;
        if (k == 2'd2) begin
          state_next = S_A_CHK;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_A_MSQ;
        end
      end
      S_A_CHK: begin
        if (status.sq_zero) begin
          state_next = S_A_NEXTJ;
        end else begin
          cmd.op     = DP_SQRT_GO;
          state_next = S_A_SQW;
        end
      end
      S_A_SQW: begin
        if (!status.sqrt_busy) begin
          cmd.op     = DP_DIV_F;
          state_next = S_A_DFW;
        end
      end
      S_A_DFW: begin
        if (!status.div_busy) begin
          cmd.op     = DP_LATCH_F;
          k_next     = '0;
          state_next = S_A_DU;
        end
      end
      S_A_DU: begin
        cmd.op     = DP_DIV_U;
        state_next = S_A_DUW;
      end
      S_A_DUW: begin
        if (!status.div_busy) begin
          cmd.op     = DP_LATCH_U;
          state_next = S_A_MT;
        end
      end
      S_A_MT: begin
        cmd.op     = DP_MUL_T;
        state_next = S_A_AT;
      end
      S_A_AT: begin
        cmd.op = DP_ACC_T;
        if (k == 2'd2) begin
          state_next = S_A_NEXTJ;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_A_DU;
        end
      end
      S_A_NEXTJ: begin
        k_next = '0;
        if (last_j) begin
          state_next = S_A_MG;
        end else begin
          j_next     = j + IW'(1);
          state_next = S_A_RDJ;
        end
      end
      S_A_MG: begin
        cmd.op     = DP_MUL_G;
        state_next = S_A_AG;
      end
      S_A_AG: begin
        cmd.op = DP_ACC_G;
        if (k == 2'd2) begin
          state_next = S_A_WRA;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_A_MG;
        end
      end
      S_A_WRA: begin
        cmd.op     = DP_WR_ACC;
        state_next = S_A_NEXTI;
      end
      S_A_NEXTI: begin
        if (last_i) begin
          i_next     = '0;
          state_next = S_B_RD;
        end else begin
          i_next     = i + IW'(1);
          state_next = S_A_RDI;
        end
      end
      S_B_RD: state_next = S_B_LAT;
      S_B_LAT: begin
        cmd.op     = DP_LATCH_B;
        k_next     = '0;
        state_next = status.pinned ? S_B_NEXT : S_B_MA;
      end
      S_B_MA: begin
        cmd.op     = DP_MUL_A;
        state_next = S_B_AV;
      end
      S_B_AV: begin
        cmd.op     = DP_ACC_V;
        state_next = S_B_MV;
      end
      S_B_MV: begin
        cmd.op     = DP_MUL_V;
        state_next = S_B_AP;
      end
      S_B_AP: begin
        cmd.op = DP_ACC_P;
        if (k == 2'd2) begin
          state_next = S_B_WR;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_B_MA;
        end
      end
      S_B_WR: begin
        cmd.op     = DP_WR_PV;
        state_next = S_B_NEXT;
      end
      S_B_NEXT: begin
        if (last_i) begin
          i_next     = '0;
          state_next = S_C_RD;
        end else begin
          i_next     = i + IW'(1);
          state_next = S_B_RD;
        end
      end
      S_C_RD: state_next = S_C_LAT;
      S_C_LAT: begin
        cmd.op     = DP_LATCH_OUT;
        state_next = S_C_OUT;
      end
      S_C_OUT: begin
        if (out_ready) begin
          if (last_i) begin
            state_next = S_IDLE;
          end else begin
            i_next     = i + IW'(1);
            state_next = S_C_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
